/* rtl/drop_oldest_frame_queue_defines.svh */
// Assertion macros used by the port-level checker of the frame queue.
`ifndef DROP_OLDEST_FRAME_QUEUE_DEFINES_SVH
`define DROP_OLDEST_FRAME_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DOFQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DOFQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dofq_pkg.sv */
// Package with the types and constants of the frame queue.
`default_nettype none

package dofq_pkg;

  localparam int FRAME_BYTES_DEF = 47;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int FUNC_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int NUM_W    = 8;
  localparam int TOTAL_W  = 5;
  localparam int LENGTH_W = 10;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND = 3'd0,
    FN_CLEAR  = 3'd1,
    FN_DROP   = 3'd2,
    FN_REMOVE = 3'd3,
    FN_READ   = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DROP,
    S_RESULT,
    S_RADDR,
    S_RDATA
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_LOAD
  } cell_mode_t;

endpackage

`default_nettype wire

/* rtl/drop_oldest_frame_queue.sv */
// Top level of the drop-oldest frame queue.
//
// Channel  Handshake              Fields
// in       in_valid / in_stall    func, data_byte, last_byte, drop_number, frame_index
// out      out_valid / out_stall  ok, overwrote, frame_total, byte_length, has_data,
//                                 out_byte, last_out
//
// Append, clear, remove and rejected operations load their result in the execute state,
// and the block takes no new transfer until it is back in the idle state.
// A drop that removes n frames goes from the execute state to the drop state, which
// shifts the slot order cells once for each frame, and loads its result in the result state.
// A read passes through the address state, which drives the registered read port of the
// frame memory, and the data state, which loads one byte; the two repeat for each byte.
// Reset is synchronous and empties the queue; memory contents are not cleared.
// While a result waits under out_stall, the next input transfer is taken into the
// operation registers, and it loads no result until the output register is free.
`default_nettype none

module drop_oldest_frame_queue #(
  parameter int FRAME_BYTES = dofq_pkg::FRAME_BYTES_DEF,
  parameter int QUEUE_DEPTH = dofq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [dofq_pkg::FUNC_W-1:0]    func,
  input  logic [dofq_pkg::BYTE_W-1:0]    data_byte,
  input  logic                           last_byte,
  input  logic [dofq_pkg::NUM_W-1:0]     drop_number,
  input  logic [dofq_pkg::NUM_W-1:0]     frame_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           ok,
  output logic                           overwrote,
  output logic [dofq_pkg::TOTAL_W-1:0]   frame_total,
  output logic [dofq_pkg::LENGTH_W-1:0]  byte_length,
  output logic                           has_data,
  output logic [dofq_pkg::BYTE_W-1:0]    out_byte,
  output logic                           last_out
);

  localparam int FUNC_W   = dofq_pkg::FUNC_W;
  localparam int BYTE_W   = dofq_pkg::BYTE_W;
  localparam int NUM_W    = dofq_pkg::NUM_W;
  localparam int TOTAL_W  = dofq_pkg::TOTAL_W;
  localparam int LENGTH_W = dofq_pkg::LENGTH_W;
  localparam int SLOTS    = QUEUE_DEPTH + 1;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int DEPTH    = SLOTS * FRAME_BYTES;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int LEN_W    = $clog2(FRAME_BYTES + 2);
  localparam int BCNT_W   = $clog2(FRAME_BYTES + 1);
  localparam int PROD_W   = CNT_W + $clog2(FRAME_BYTES + 1);

  dofq_pkg::state_t     state, state_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [SLOT_W-1:0]    stage_slot, stage_next;
  logic [LEN_W-1:0]     len, len_next;
  logic [CNT_W-1:0]     drop_left, drop_left_next;
  logic [BCNT_W-1:0]    bcnt, bcnt_next;

  logic [FUNC_W-1:0]    func_q;
  logic [BYTE_W-1:0]    byte_q;
  logic                 last_q;
  logic [NUM_W-1:0]     num_q;
  logic [NUM_W-1:0]     idx_q;

  logic [SLOT_W-1:0]    cell_slot [QUEUE_DEPTH];
  dofq_pkg::cell_mode_t cell_mode [QUEUE_DEPTH];
  logic [SLOT_W-1:0]    shift_in;
  logic [SLOT_W-1:0]    sel_slot;
  logic [SLOT_W-1:0]    free_slot;
  logic [NUM_W-1:0]     rm_idx;

  logic                 out_free;
  logic                 out_load;
  logic                 res_ok;
  logic                 res_ovw;
  logic [BYTE_W-1:0]    res_byte;
  logic                 res_last;

  logic                 stage_wr;
  logic [LEN_W-1:0]     len_inc;
  logic                 full;
  logic                 idx_hit;
  logic [CNT_W-1:0]     drop_amt;

  logic                 mem_we;
  logic                 mem_re;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [ADDR_W-1:0]    mem_raddr;
  logic [BYTE_W-1:0]    rd_data;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [SLOT_W-1:0] right;
    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign right = shift_in;
    end else begin : g_mid
      assign right = cell_slot[g+1];
    end
    dofq_cell #(
      .SLOT_W(SLOT_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .mode      (cell_mode[g]),
      .init_slot (SLOT_W'(g + 1)),
      .next_slot (right),
      .load_slot (stage_slot),
      .slot      (cell_slot[g])
    );
  end

  dofq_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (BYTE_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (byte_q),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  assign in_stall = (state != dofq_pkg::S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign rm_idx   = (state == dofq_pkg::S_DROP) ? '0 : idx_q;

  assign stage_wr = (len < LEN_W'(FRAME_BYTES));
  assign len_inc  = stage_wr ? LEN_W'(len + 1'b1) : LEN_W'(FRAME_BYTES + 1);
  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign idx_hit  = (idx_q < NUM_W'(count));
  assign drop_amt = (num_q > NUM_W'(count)) ? count : num_q[CNT_W-1:0];

  assign mem_waddr = ADDR_W'(ADDR_W'(stage_slot) * ADDR_W'(FRAME_BYTES) + ADDR_W'(len));
  assign mem_raddr = ADDR_W'(ADDR_W'(sel_slot) * ADDR_W'(FRAME_BYTES) + ADDR_W'(bcnt));
  assign mem_re    = (state == dofq_pkg::S_RADDR);

  always_comb begin
    sel_slot  = '0;
    free_slot = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (NUM_W'(i) == rm_idx) begin
        sel_slot = cell_slot[i];
      end
      if (CNT_W'(i) == count) begin
        free_slot = cell_slot[i];
      end
    end
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    stage_next     = stage_slot;
    len_next       = len;
    drop_left_next = drop_left;
    bcnt_next      = bcnt;
    shift_in       = sel_slot;
    mem_we         = 1'b0;
    out_load       = 1'b0;
    res_ok         = 1'b0;
    res_ovw        = 1'b0;
    res_byte       = '0;
    res_last       = 1'b1;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cell_mode[i] = dofq_pkg::CELL_HOLD;
    end

    case (state)
      dofq_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = dofq_pkg::S_EXEC;
        end
      end

      dofq_pkg::S_EXEC: begin
        case (func_q)
          dofq_pkg::FN_APPEND: begin
            if (out_free) begin
              mem_we   = stage_wr;
              res_ok   = stage_wr;
              len_next = len_inc;
              if (last_q) begin
                len_next = '0;
                res_ok   = 1'b0;
                if (len_inc == LEN_W'(FRAME_BYTES)) begin
                  res_ok = 1'b1;
                  if (full) begin
                    for (int i = 0; i < QUEUE_DEPTH; i++) begin
                      cell_mode[i] = dofq_pkg::CELL_SHIFT;
                    end
                    shift_in   = stage_slot;
                    stage_next = cell_slot[0];
                    res_ovw    = 1'b1;
                  end else begin
                    for (int i = 0; i < QUEUE_DEPTH; i++) begin
                      if (CNT_W'(i) == count) begin
                        cell_mode[i] = dofq_pkg::CELL_LOAD;
                      end
                    end
                    stage_next = free_slot;
                    count_next = CNT_W'(count + 1'b1);
                  end
                end
              end
              out_load   = 1'b1;
              state_next = dofq_pkg::S_IDLE;
            end
          end
          dofq_pkg::FN_CLEAR: begin
            if (out_free) begin
              count_next = '0;
              res_ok     = 1'b1;
              out_load   = 1'b1;
              state_next = dofq_pkg::S_IDLE;
            end
          end
          dofq_pkg::FN_DROP: begin
            if (drop_amt != '0) begin
              drop_left_next = drop_amt;
              state_next     = dofq_pkg::S_DROP;
            end else if (out_free) begin
              out_load   = 1'b1;
              state_next = dofq_pkg::S_IDLE;
            end
          end
          dofq_pkg::FN_REMOVE: begin
            if (out_free) begin
              if (idx_hit) begin
                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                  if (NUM_W'(i) >= idx_q) begin
                    cell_mode[i] = dofq_pkg::CELL_SHIFT;
                  end
                end
                count_next = CNT_W'(count - 1'b1);
                res_ok     = 1'b1;
              end
              out_load   = 1'b1;
              state_next = dofq_pkg::S_IDLE;
            end
          end
          dofq_pkg::FN_READ: begin
            if (idx_hit) begin
              bcnt_next  = '0;
              state_next = dofq_pkg::S_RADDR;
            end else if (out_free) begin
              out_load   = 1'b1;
              state_next = dofq_pkg::S_IDLE;
            end
          end
          default: begin
            if (out_free) begin
              out_load   = 1'b1;
              state_next = dofq_pkg::S_IDLE;
            end
          end
        endcase
      end

      dofq_pkg::S_DROP: begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          cell_mode[i] = dofq_pkg::CELL_SHIFT;
        end
        count_next     = CNT_W'(count - 1'b1);
        drop_left_next = CNT_W'(drop_left - 1'b1);
        if (drop_left == CNT_W'(1)) begin
          state_next = dofq_pkg::S_RESULT;
        end
      end

      dofq_pkg::S_RESULT: begin
        if (out_free) begin
          res_ok     = 1'b1;
          out_load   = 1'b1;
          state_next = dofq_pkg::S_IDLE;
        end
      end

      dofq_pkg::S_RADDR: begin
        state_next = dofq_pkg::S_RDATA;
      end

      dofq_pkg::S_RDATA: begin
        if (out_free) begin
          res_ok   = 1'b1;
          res_byte = rd_data;
          res_last = (bcnt == BCNT_W'(FRAME_BYTES - 1));
          out_load = 1'b1;
          if (res_last) begin
            state_next = dofq_pkg::S_IDLE;
          end else begin
            bcnt_next  = BCNT_W'(bcnt + 1'b1);
            state_next = dofq_pkg::S_RADDR;
          end
        end
      end

      default: begin
        state_next = dofq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dofq_pkg::S_IDLE;
      count      <= '0;
      stage_slot <= '0;
      len        <= '0;
      drop_left  <= '0;
      bcnt       <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      stage_slot <= stage_next;
      len        <= len_next;
      drop_left  <= drop_left_next;
      bcnt       <= bcnt_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      func_q <= func;
      byte_q <= data_byte;
      last_q <= last_byte;
      num_q  <= drop_number;
      idx_q  <= frame_index;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ok          <= res_ok;
      overwrote   <= res_ovw;
      frame_total <= TOTAL_W'(count_next);
      byte_length <= LENGTH_W'(PROD_W'(count_next) * PROD_W'(FRAME_BYTES));
      has_data    <= (count_next != '0);
      out_byte    <= res_byte;
      last_out    <= res_last;
    end
  end

endmodule

`default_nettype wire

/* rtl/dofq_cell.sv */
// One cell of the slot order chain: holds the memory slot of one queue position.
`default_nettype none

module dofq_cell #(
  parameter int SLOT_W = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dofq_pkg::cell_mode_t mode,
  input  logic [SLOT_W-1:0]    init_slot,
  input  logic [SLOT_W-1:0]    next_slot,
  input  logic [SLOT_W-1:0]    load_slot,
  output logic [SLOT_W-1:0]    slot
);

  logic [SLOT_W-1:0] slot_next;

  always_comb begin
    case (mode)
      dofq_pkg::CELL_SHIFT: slot_next = next_slot;
      dofq_pkg::CELL_LOAD:  slot_next = load_slot;
      default:              slot_next = slot;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= init_slot;
    end else begin
      slot <= slot_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/dofq_ram.sv */
// Single-port-write, registered-read byte memory for frame slots.
`default_nettype none

module dofq_ram #(
  parameter int DEPTH  = 799,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/dofq_check.sv */
// Port-level checker for the frame queue and its bind to the top level.
`default_nettype none

`include "drop_oldest_frame_queue_defines.svh"

module dofq_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         ok,
  input logic                         overwrote,
  input logic [dofq_pkg::TOTAL_W-1:0] frame_total,
  input logic                         has_data,
  input logic [dofq_pkg::BYTE_W-1:0]  out_byte,
  input logic                         last_out
);

  `DOFQ_ASSERT_NOW(a_empty_total, out_valid && !has_data, frame_total == '0, "empty queue reports frames")
  `DOFQ_ASSERT_NOW(a_reject_single, out_valid && !ok, last_out && out_byte == '0, "rejected operation gave a byte run")
  `DOFQ_ASSERT_NOW(a_run_is_read, out_valid && !last_out, ok && !overwrote && has_data, "byte run without a stored frame")
  `DOFQ_ASSERT_NOW(a_overwrite_ok, out_valid && overwrote, ok && last_out && has_data, "overwrite flagged on a failed append")
  `DOFQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(last_out) && $stable(ok), "stalled result changed")

endmodule

bind drop_oldest_frame_queue dofq_check u_dofq_check (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .ok          (ok),
  .overwrote   (overwrote),
  .frame_total (frame_total),
  .has_data    (has_data),
  .out_byte    (out_byte),
  .last_out    (last_out)
);

`default_nettype wire

/* verif/frame_queue_checker.sv */
// Checker that predicts and compares the results of the drop-oldest frame queue.
`timescale 1ns / 100ps

module frame_queue_checker #(
  parameter int FRAME_BYTES = dofq_pkg::FRAME_BYTES_DEF,
  parameter int QUEUE_DEPTH = dofq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [dofq_pkg::FUNC_W-1:0]   func,
  input  logic [dofq_pkg::BYTE_W-1:0]   data_byte,
  input  logic                          last_byte,
  input  logic [dofq_pkg::NUM_W-1:0]    drop_number,
  input  logic [dofq_pkg::NUM_W-1:0]    frame_index,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          ok,
  input  logic                          overwrote,
  input  logic [dofq_pkg::TOTAL_W-1:0]  frame_total,
  input  logic [dofq_pkg::LENGTH_W-1:0] byte_length,
  input  logic                          has_data,
  input  logic [dofq_pkg::BYTE_W-1:0]   out_byte,
  input  logic                          last_out,
  output int unsigned                   fail_count,
  output int unsigned                   pending,
  output int unsigned                   frames_held
);

  localparam int FUNC_W   = dofq_pkg::FUNC_W;
  localparam int BYTE_W   = dofq_pkg::BYTE_W;
  localparam int NUM_W    = dofq_pkg::NUM_W;
  localparam int TOTAL_W  = dofq_pkg::TOTAL_W;
  localparam int LENGTH_W = dofq_pkg::LENGTH_W;

  typedef struct packed {
    logic                ok;
    logic                overwrote;
    logic [TOTAL_W-1:0]  frame_total;
    logic [LENGTH_W-1:0] byte_length;
    logic                has_data;
    logic [BYTE_W-1:0]   out_byte;
    logic                last_out;
  } queue_result_t;

  logic [BYTE_W-1:0] frame_mem [QUEUE_DEPTH*FRAME_BYTES];
  logic [BYTE_W-1:0] staging [FRAME_BYTES];
  int unsigned       held_count;
  int unsigned       staged_count;
  int unsigned       mismatches;
  queue_result_t     predicted_results [$];

  initial begin
    fail_count      = 0;
    pending         = 0;
    frames_held     = 0;
    held_count      = 0;
    staged_count    = 0;
    mismatches      = 0;
  end

  function automatic void push_result(logic res_ok, logic res_ovw, logic [BYTE_W-1:0] res_byte,
                                      logic res_last);
    queue_result_t r;
    r.ok          = res_ok;
    r.overwrote   = res_ovw;
    r.frame_total = TOTAL_W'(held_count);
    r.byte_length = LENGTH_W'(held_count * FRAME_BYTES);
    r.has_data    = (held_count != 0);
    r.out_byte    = res_byte;
    r.last_out    = res_last;
    predicted_results.push_back(r);
  endfunction

  function automatic void shift_frames(int unsigned dst_frame, int unsigned src_frame,
                                       int unsigned n_frames);
    int unsigned i;
    for (i = 0; i < n_frames * FRAME_BYTES; i++) begin
      frame_mem[dst_frame*FRAME_BYTES + i] = frame_mem[src_frame*FRAME_BYTES + i];
    end
  endfunction

  function automatic void apply_queue_op(logic [FUNC_W-1:0] code, logic [BYTE_W-1:0] din,
                                         logic din_last, logic [NUM_W-1:0] dropn,
                                         logic [NUM_W-1:0] idx);
    logic        done;
    logic        ovw;
    int unsigned n;
    int unsigned slot;
    int unsigned i;
    done = 1'b0;
    ovw  = 1'b0;
    case (code)
      dofq_pkg::FN_APPEND: begin
        if (staged_count < FRAME_BYTES) begin
          staging[staged_count] = din;
          staged_count++;
          done = 1'b1;
        end else begin
          staged_count = FRAME_BYTES + 1;
        end
        if (din_last) begin
          done = 1'b0;
          if (staged_count == FRAME_BYTES) begin
            if (held_count >= QUEUE_DEPTH) begin
              shift_frames(0, 1, QUEUE_DEPTH - 1);
              slot = QUEUE_DEPTH - 1;
              ovw  = 1'b1;
            end else begin
              slot = held_count;
              held_count++;
            end
            for (i = 0; i < FRAME_BYTES; i++) begin
              frame_mem[slot*FRAME_BYTES + i] = staging[i];
            end
            done = 1'b1;
          end
          staged_count = 0;
        end
      end
      dofq_pkg::FN_CLEAR: begin
        held_count = 0;
        done       = 1'b1;
      end
      dofq_pkg::FN_DROP: begin
        n = dropn;
        if (n > held_count) n = held_count;
        if (n != 0) begin
          shift_frames(0, n, held_count - n);
          held_count = held_count - n;
          done       = 1'b1;
        end
      end
      dofq_pkg::FN_REMOVE: begin
        if (idx < held_count) begin
          shift_frames(idx, idx + 1, held_count - idx - 1);
          held_count--;
          done = 1'b1;
        end
      end
      dofq_pkg::FN_READ: begin
        if (idx < held_count) begin
          for (i = 0; i < FRAME_BYTES; i++) begin
            push_result(1'b1, 1'b0, frame_mem[idx*FRAME_BYTES + i], i == FRAME_BYTES - 1);
          end
          return;
        end
      end
      default: ;
    endcase
    push_result(done, ovw, '0, 1'b1);
  endfunction

  task automatic compare_field(string field, logic [LENGTH_W-1:0] want, logic [LENGTH_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    queue_result_t want;
    if (rst) begin
      held_count   = 0;
      staged_count = 0;
      predicted_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        apply_queue_op(func, data_byte, last_byte, drop_number, frame_index);
      end
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          $error("unexpected result transfer: ok=%0b frame_total=%0d out_byte=%0d",
                 ok, frame_total, out_byte);
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          compare_field("ok", LENGTH_W'(want.ok), LENGTH_W'(ok));
          compare_field("overwrote", LENGTH_W'(want.overwrote), LENGTH_W'(overwrote));
          compare_field("frame_total", LENGTH_W'(want.frame_total), LENGTH_W'(frame_total));
          compare_field("byte_length", want.byte_length, byte_length);
          compare_field("has_data", LENGTH_W'(want.has_data), LENGTH_W'(has_data));
          compare_field("out_byte", LENGTH_W'(want.out_byte), LENGTH_W'(out_byte));
          compare_field("last_out", LENGTH_W'(want.last_out), LENGTH_W'(last_out));
        end
      end
    end
    fail_count      <= mismatches;
    pending         <= predicted_results.size();
    frames_held     <= held_count;
  end

endmodule

/* verif/tb_top.sv */
// Testbench top that drives the drop-oldest frame queue and reports the verdict.
`timescale 1ns / 100ps

module tb_top;

  localparam int FUNC_W   = dofq_pkg::FUNC_W;
  localparam int BYTE_W   = dofq_pkg::BYTE_W;
  localparam int NUM_W    = dofq_pkg::NUM_W;
  localparam int TOTAL_W  = dofq_pkg::TOTAL_W;
  localparam int LENGTH_W = dofq_pkg::LENGTH_W;

  localparam int FRAME_BYTES = dofq_pkg::FRAME_BYTES_DEF;
  localparam int QUEUE_DEPTH = dofq_pkg::QUEUE_DEPTH_DEF;

  localparam logic [FUNC_W-1:0] FN_SPARE_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_LAST  = 3'd7;

  localparam int ITEM_TARGET      = 250;
  localparam int PAUSE_AT         = 170;
  localparam int HOLD_START       = 60;
  localparam int HOLD_CYCLES      = 300;
  localparam int DRAIN_CYCLES     = 100;
  localparam int CYCLE_LIMIT      = 2000000;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [FUNC_W-1:0]   func;
  logic [BYTE_W-1:0]   data_byte;
  logic                last_byte;
  logic [NUM_W-1:0]    drop_number;
  logic [NUM_W-1:0]    frame_index;
  logic                out_valid;
  logic                out_stall;
  logic                ok;
  logic                overwrote;
  logic [TOTAL_W-1:0]  frame_total;
  logic [LENGTH_W-1:0] byte_length;
  logic                has_data;
  logic [BYTE_W-1:0]   out_byte;
  logic                last_out;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned frames_held;
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned cycle_count;

  drop_oldest_frame_queue #(
    .FRAME_BYTES(FRAME_BYTES),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .drop_number(drop_number),
    .frame_index(frame_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ok         (ok),
    .overwrote  (overwrote),
    .frame_total(frame_total),
    .byte_length(byte_length),
    .has_data   (has_data),
    .out_byte   (out_byte),
    .last_out   (last_out)
  );

  frame_queue_checker #(
    .FRAME_BYTES(FRAME_BYTES),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .drop_number    (drop_number),
    .frame_index    (frame_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .ok             (ok),
    .overwrote      (overwrote),
    .frame_total    (frame_total),
    .byte_length    (byte_length),
    .has_data       (has_data),
    .out_byte       (out_byte),
    .last_out       (last_out),
    .fail_count     (fail_count),
    .pending        (pending),
    .frames_held    (frames_held)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_item(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] d, logic l,
                           logic [NUM_W-1:0] n, logic [NUM_W-1:0] x);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid    <= 1'b1;
    func        <= f;
    data_byte   <= d;
    last_byte   <= l;
    drop_number <= n;
    frame_index <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_bytes(int unsigned len, logic end_mark);
    int unsigned i;
    for (i = 0; i < len; i++) begin
      send_item(dofq_pkg::FN_APPEND, 8'($urandom_range(0, 255)), end_mark && (i == len - 1),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
  endtask

  function automatic logic [NUM_W-1:0] pick_index();
    if (frames_held > 0) return NUM_W'($urandom_range(0, frames_held - 1));
    return NUM_W'($urandom_range(0, 255));
  endfunction

  task automatic send_command();
    int unsigned      pick;
    int unsigned      drop_pick;
    logic [NUM_W-1:0] n;
    logic [BYTE_W-1:0] d;
    logic             l;
    pick = $urandom_range(0, 99);
    d    = 8'($urandom_range(0, 255));
    l    = 1'($urandom_range(0, 1));
    if (pick < 40) begin
      send_item(dofq_pkg::FN_READ, d, l, 8'($urandom_range(0, 255)), pick_index());
    end else if (pick < 48) begin
      send_item(dofq_pkg::FN_READ, d, l, 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
    end else if (pick < 68) begin
      send_item(dofq_pkg::FN_REMOVE, d, l, 8'($urandom_range(0, 255)), pick_index());
    end else if (pick < 72) begin
      send_item(dofq_pkg::FN_REMOVE, d, l, 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
    end else if (pick < 88) begin
      drop_pick = $urandom_range(0, 9);
      if (drop_pick == 0) n = '0;
      else if (drop_pick == 1) n = '1;
      else if (drop_pick == 2) n = 8'($urandom_range(0, 255));
      else n = 8'($urandom_range(1, 3));
      send_item(dofq_pkg::FN_DROP, d, l, n, 8'($urandom_range(0, 255)));
    end else if (pick < 93) begin
      send_item(dofq_pkg::FN_CLEAR, d, l, 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
    end else begin
      send_item(3'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST)), d, l,
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    burst_left = 0;
  endtask

  initial begin
    int unsigned       pick;
    int unsigned       cut;
    logic              paused;
    logic [FUNC_W-1:0] spare;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    func        <= dofq_pkg::FN_APPEND;
    data_byte   <= '0;
    last_byte   <= 1'b0;
    drop_number <= '0;
    frame_index <= '0;
    items_sent     = 0;
    burst_left     = 0;
    paused         = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Operations on an empty queue, the spare codes and short frames.
    send_item(dofq_pkg::FN_CLEAR, '0, 1'b0, '0, '0);
    send_item(dofq_pkg::FN_DROP, '1, 1'b1, '0, '1);
    send_item(dofq_pkg::FN_DROP, '0, 1'b0, '1, '0);
    send_item(dofq_pkg::FN_REMOVE, '1, 1'b1, '1, '0);
    send_item(dofq_pkg::FN_READ, '0, 1'b0, '0, '0);
    send_item(dofq_pkg::FN_READ, '1, 1'b1, '1, '1);
    for (spare = FN_SPARE_FIRST; spare != dofq_pkg::FN_APPEND; spare++) begin
      send_item(spare, '1, 1'b1, '1, '1);
    end
    send_item(dofq_pkg::FN_APPEND, '0, 1'b1, '0, '0);
    send_item(dofq_pkg::FN_APPEND, '1, 1'b1, '1, '1);
    send_item(dofq_pkg::FN_APPEND, 8'h5A, 1'b0, '0, '0);
    send_item(dofq_pkg::FN_APPEND, 8'hA5, 1'b1, '0, '0);
    wait_for_drain();

    while (items_sent < ITEM_TARGET) begin
      if (!paused && items_sent >= PAUSE_AT) begin
        paused = 1'b1;
        wait_for_drain();
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_bytes(FRAME_BYTES, 1'b1);
      end else if (pick < 65) begin
        // A command in the middle of a frame must not disturb the staged bytes.
        cut = $urandom_range(1, FRAME_BYTES - 1);
        send_bytes(cut, 1'b0);
        send_command();
        send_bytes(FRAME_BYTES - cut, 1'b1);
      end else if (pick < 68) begin
        send_bytes($urandom_range(1, FRAME_BYTES - 1), 1'b1);
      end else if (pick < 71) begin
        send_bytes($urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 13), 1'b1);
      end else if (pick < 73) begin
        send_item(dofq_pkg::FN_APPEND, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else begin
        send_command();
      end
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("drop_oldest_frame_queue test passed");
    end else begin
      $display("drop_oldest_frame_queue test failed");
    end
    $finish;
  end

  initial begin
    int unsigned phase_left;
    int unsigned stall_pct;
    logic        hold_done;
    out_stall <= 1'b0;
    phase_left = 0;
    stall_pct  = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      // One long hold-off lets the block fill up and stall its input.
      if (!hold_done && items_sent >= HOLD_START) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (phase_left == 0) begin
        phase_left = $urandom_range(8, 80);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 30;
          2:       stall_pct = 70;
          default: stall_pct = 95;
        endcase
      end
      phase_left--;
      out_stall <= ($urandom_range(1, 100) <= stall_pct);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("drop_oldest_frame_queue test failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/dofq_pkg.sv
rtl/dofq_cell.sv
rtl/dofq_ram.sv
rtl/drop_oldest_frame_queue.sv
rtl/dofq_check.sv
verif/frame_queue_checker.sv
verif/tb_top.sv
